// ===== rtl/hco_pkg.sv =====
package hco_pkg;

   localparam int DefFrameWidth  = 1024;
   localparam int DefFrameHeight = 768;
   localparam int IconCount      = 5;
   localparam int IconSize       = 16;

   typedef enum logic [2:0] {
      CSR_ENABLE    = 3'd0,
      CSR_SHAPE     = 3'd1,
      CSR_POINTER_X = 3'd2,
      CSR_POINTER_Y = 3'd3,
      CSR_DARK      = 3'd4,
      CSR_LIGHT     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PIX_CLEAR,
      PIX_DARK,
      PIX_LIGHT
   } pix_type;

   typedef struct packed {
      logic        enable;
      logic [2:0]  shape;
      logic [9:0]  pointer_x;
      logic [9:0]  pointer_y;
      logic [15:0] dark;
      logic [15:0] light;
   } cursor_cfg_type;

   typedef logic [8*IconSize-1:0] art_row_type;

   // icon art, one ascii char per pixel: '.' clear, 'B' dark, 'W' light
   localparam art_row_type ICON_ART [IconCount][IconSize] = '{
      '{ "B...............", "BB..............", "BWB.............", "BWWB............",
         "BWWWB...........", "BWWWWB..........", "BWWWWWB.........", "BWWWWWWB........",
         "BWWWWWWWB.......", "BWWWWWWWWB......", "BWWWWWBBBBB.....", "BWWBWWB.........",
         "BWB.BWWB........", "BB..BWWB........", "B....BWWB.......", "......BB........" },
      '{ "....BB..........", "...BWWB.........", "...BWWB.........", "...BWWB.........",
         "..BBWWB.........", ".BWWWWB.........", "BBWWWWB.........", "BWWWWWB.........",
         "BWWWWWB.........", "BWWWWWB.........", "BWWWWWB.........", ".BWWWWB.........",
         ".BWWWWB.........", "..BWWB..........", "...BB...........", "................" },
      '{ ".......BB.......", ".......BB.......", ".......BB.......", ".......BB.......",
         ".......BB.......", ".......BB.......", "..BBBBBWWBBBBB..", "..BBBBBWWBBBBB..",
         ".......BB.......", ".......BB.......", ".......BB.......", ".......BB.......",
         ".......BB.......", ".......BB.......", ".......BB.......", "................" },
      '{ "...BBBBB........", "..BBWWWBB.......", ".BBWWWWWBB......", ".BBWBBBWBB......",
         "...BWWWB........", "...BWWBB........", "....BBWBB.......", ".....BWBB.......",
         ".....BWB........", ".....BWB........", "................", ".....BWB........",
         ".....BWB........", ".....BBB........", "................", "................" },
      '{ ".....BBBBB......", "...BBWWWWWBB....", "..BWWWWWWWWWB...", ".BWWWWBBBBBWWB..",
         ".BWWBBWWWWBWWB..", "BWWBBWWWWWWBWWB.", "BWWBWWWWWWWWBWWB", "BWBWWWWWWWWWWBWB",
         "BWBWWWWWWWWWWBWB", "BWWBWWWWWWWWBWWB", "BWWBBWWWWWWBWWB.", ".BWWBBWWWWBWWB..",
         ".BWWWWBBBBBWWB..", "..BWWWWWWWWWB...", "...BBWWWWWBB....", ".....BBBBB......" }
   };

   localparam logic [4:0] ICON_W  [IconCount] = '{5'd12, 5'd12, 5'd16, 5'd16, 5'd16};
   localparam logic [4:0] ICON_H  [IconCount] = '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16};
   localparam logic [3:0] ICON_HX [IconCount] = '{4'd0, 4'd0, 4'd7, 4'd0, 4'd7};
   localparam logic [3:0] ICON_HY [IconCount] = '{4'd0, 4'd0, 4'd6, 4'd0, 4'd7};

   function automatic pix_type icon_pixel(logic [2:0] icon, logic [3:0] row, logic [3:0] col);
      art_row_type line;
      logic [7:0]  ch;
      line = ICON_ART[icon][row];
      ch   = line[{~col, 3'b000} +: 8];
      if (ch == "B") begin
         return PIX_DARK;
      end else if (ch == "W") begin
         return PIX_LIGHT;
      end
      return PIX_CLEAR;
   endfunction

endpackage

// ===== rtl/hco_overlay.sv =====
module hco_overlay #(
   parameter int FRAME_WIDTH  = hco_pkg::DefFrameWidth,
   parameter int FRAME_HEIGHT = hco_pkg::DefFrameHeight
) (
   input  hco_pkg::cursor_cfg_type cfg,
   input  logic [9:0]              pixel_x,
   input  logic [9:0]              pixel_y,
   input  logic [15:0]             pixel_in,
   output logic [15:0]             pixel_out,
   output logic                    on_cursor
);
   import hco_pkg::*;

   localparam logic [12:0] FrameW = 13'(FRAME_WIDTH);
   localparam logic [12:0] FrameH = 13'(FRAME_HEIGHT);

   logic [2:0]  icon;
   logic        on_frame;
   logic [11:0] dx;
   logic [11:0] dy;
   logic        in_box;
   pix_type     pix;

   assign icon     = (cfg.shape < 3'(IconCount)) ? cfg.shape : 3'd0;
   assign on_frame = ({3'b000, pixel_x} < FrameW) && ({3'b000, pixel_y} < FrameH);

   // offset into the icon box, signed
   assign dx = {2'b00, pixel_x} - {2'b00, cfg.pointer_x} + {8'd0, ICON_HX[icon]};
   assign dy = {2'b00, pixel_y} - {2'b00, cfg.pointer_y} + {8'd0, ICON_HY[icon]};

   assign in_box = !dx[11] && !dy[11]
                   && (dx[10:0] < {6'd0, ICON_W[icon]})
                   && (dy[10:0] < {6'd0, ICON_H[icon]});

   assign pix = icon_pixel(icon, dy[3:0], dx[3:0]);

   always_comb begin
      pixel_out = pixel_in;
      on_cursor = 1'b0;
      if (cfg.enable && on_frame && in_box) begin
         unique case (pix)
            PIX_DARK: begin
               pixel_out = cfg.dark;
               on_cursor = 1'b1;
            end
            PIX_LIGHT: begin
               pixel_out = cfg.light;
               on_cursor = 1'b1;
            end
            default: begin
               pixel_out = pixel_in;
               on_cursor = 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== rtl/hardware_cursor_overlay_unit.sv =====
// Hardware cursor overlay: one pixel in, one pixel out, one beat per clock sustained
// while rsp_ready is high. Each pixel passes an input register, then the icon lookup
// and color select, then an output register, and the pipeline keeps moving whenever
// rsp_ready is high. The icon box is placed so that the selected icon's hotspot sits
// on pointer_x/pointer_y; when enabled, opaque icon pixels inside the frame take the
// dark or light colour and raise rsp_on_cursor. Registers are written through
// csr_wr_en/csr_index/csr_wdata and should change only while no beat is in flight.
module hardware_cursor_overlay_unit #(
   parameter int FRAME_WIDTH  = hco_pkg::DefFrameWidth,
   parameter int FRAME_HEIGHT = hco_pkg::DefFrameHeight
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_pixel_x,
   input  logic [9:0]  req_pixel_y,
   input  logic [15:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_out,
   output logic        rsp_on_cursor
);
   import hco_pkg::*;

   cursor_cfg_type cfg_ff;

   logic        in_vld_ff;
   logic [9:0]  in_x_ff;
   logic [9:0]  in_y_ff;
   logic [15:0] in_pix_ff;

   logic        out_vld_ff;
   logic [15:0] out_pix_ff;
   logic        out_hit_ff;

   logic [15:0] pix_in;
   logic        hit_in;
   logic        advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b0, shape: 3'd0, pointer_x: 10'd0, pointer_y: 10'd0,
                     dark: 16'h0000, light: 16'hFFFF};
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:    cfg_ff.enable    <= csr_wdata[0];
            CSR_SHAPE:     cfg_ff.shape     <= csr_wdata[2:0];
            CSR_POINTER_X: cfg_ff.pointer_x <= csr_wdata[9:0];
            CSR_POINTER_Y: cfg_ff.pointer_y <= csr_wdata[9:0];
            CSR_DARK:      cfg_ff.dark      <= csr_wdata;
            CSR_LIGHT:     cfg_ff.light     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !reset && (!in_vld_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_x_ff   <= req_pixel_x;
         in_y_ff   <= req_pixel_y;
         in_pix_ff <= req_pixel_in;
      end
   end

   hco_overlay #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_overlay (
      .cfg       (cfg_ff),
      .pixel_x   (in_x_ff),
      .pixel_y   (in_y_ff),
      .pixel_in  (in_pix_ff),
      .pixel_out (pix_in),
      .on_cursor (hit_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pix_ff <= pix_in;
         out_hit_ff <= hit_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_on_cursor = out_hit_ff;

endmodule

// ===== dv/tb_hardware_cursor_overlay_unit.sv =====
`timescale 1ns / 100ps

module tb_hardware_cursor_overlay_unit;
   import hco_pkg::*;

   localparam int FrameW = DefFrameWidth;
   localparam int FrameH = DefFrameHeight;
   localparam byte ART_DARK = "B";
   localparam byte ART_LIGHT = "W";

   // independent copy of the cursor art, one char per pixel
   localparam logic [127:0] CURSOR_ART [5][16] = '{
      '{ "B...............", "BB..............", "BWB.............", "BWWB............",
         "BWWWB...........", "BWWWWB..........", "BWWWWWB.........", "BWWWWWWB........",
         "BWWWWWWWB.......", "BWWWWWWWWB......", "BWWWWWBBBBB.....", "BWWBWWB.........",
         "BWB.BWWB........", "BB..BWWB........", "B....BWWB.......", "......BB........" },
      '{ "....BB..........", "...BWWB.........", "...BWWB.........", "...BWWB.........",
         "..BBWWB.........", ".BWWWWB.........", "BBWWWWB.........", "BWWWWWB.........",
         "BWWWWWB.........", "BWWWWWB.........", "BWWWWWB.........", ".BWWWWB.........",
         ".BWWWWB.........", "..BWWB..........", "...BB...........", "................" },
      '{ ".......BB.......", ".......BB.......", ".......BB.......", ".......BB.......",
         ".......BB.......", ".......BB.......", "..BBBBBWWBBBBB..", "..BBBBBWWBBBBB..",
         ".......BB.......", ".......BB.......", ".......BB.......", ".......BB.......",
         ".......BB.......", ".......BB.......", ".......BB.......", "................" },
      '{ "...BBBBB........", "..BBWWWBB.......", ".BBWWWWWBB......", ".BBWBBBWBB......",
         "...BWWWB........", "...BWWBB........", "....BBWBB.......", ".....BWBB.......",
         ".....BWB........", ".....BWB........", "................", ".....BWB........",
         ".....BWB........", ".....BBB........", "................", "................" },
      '{ ".....BBBBB......", "...BBWWWWWBB....", "..BWWWWWWWWWB...", ".BWWWWBBBBBWWB..",
         ".BWWBBWWWWBWWB..", "BWWBBWWWWWWBWWB.", "BWWBWWWWWWWWBWWB", "BWBWWWWWWWWWWBWB",
         "BWBWWWWWWWWWWBWB", "BWWBWWWWWWWWBWWB", "BWWBBWWWWWWBWWB.", ".BWWBBWWWWBWWB..",
         ".BWWWWBBBBBWWB..", "..BWWWWWWWWWB...", "...BBWWWWWBB....", ".....BBBBB......" }
   };
   localparam int ICON_WIDTH  [5] = '{12, 12, 16, 16, 16};
   localparam int ICON_HEIGHT [5] = '{16, 16, 16, 16, 16};
   localparam int ICON_HOT_X  [5] = '{0, 0, 7, 0, 7};
   localparam int ICON_HOT_Y  [5] = '{0, 0, 6, 0, 7};

   typedef struct packed {
      logic [15:0] pixel;
      logic        hit;
   } overlay_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_ENABLE;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [9:0]  req_pixel_x = '0;
   logic [9:0]  req_pixel_y = '0;
   logic [15:0] req_pixel_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_pixel_out;
   logic        rsp_on_cursor;

   cursor_cfg_type  cursor_cfg = '{enable: 1'b0, shape: 3'd0, pointer_x: 10'd0,
                                   pointer_y: 10'd0, dark: 16'h0000, light: 16'hFFFF};
   overlay_result_type expected_pixels [$];
   int              error_count = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;

   hardware_cursor_overlay_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_on_cursor (rsp_on_cursor)
   );

   always #4 clock = ~clock;

   function automatic int selected_icon();
      return (cursor_cfg.shape < IconCount) ? int'(cursor_cfg.shape) : 0;
   endfunction

   function automatic overlay_result_type overlay_pixel(input logic [9:0] x,
                                                        input logic [9:0] y,
                                                        input logic [15:0] colour);
      overlay_result_type r;
      int icon;
      int dx;
      int dy;
      logic [7:0] art;
      r.pixel = colour;
      r.hit   = 1'b0;
      if (cursor_cfg.enable && int'(x) < FrameW && int'(y) < FrameH) begin
         icon = selected_icon();
         dx = int'(x) - int'(cursor_cfg.pointer_x) + ICON_HOT_X[icon];
         dy = int'(y) - int'(cursor_cfg.pointer_y) + ICON_HOT_Y[icon];
         if (dx >= 0 && dx < ICON_WIDTH[icon] && dy >= 0 && dy < ICON_HEIGHT[icon]) begin
            art = CURSOR_ART[icon][dy][(15 - dx) * 8 +: 8];
            if (art == ART_DARK) begin
               r.pixel = cursor_cfg.dark;
               r.hit   = 1'b1;
            end else if (art == ART_LIGHT) begin
               r.pixel = cursor_cfg.light;
               r.hit   = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ENABLE:    cursor_cfg.enable    = value[0];
         CSR_SHAPE:     cursor_cfg.shape     = value[2:0];
         CSR_POINTER_X: cursor_cfg.pointer_x = value[9:0];
         CSR_POINTER_Y: cursor_cfg.pointer_y = value[9:0];
         CSR_DARK:      cursor_cfg.dark      = value;
         CSR_LIGHT:     cursor_cfg.light     = value;
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [9:0] x, input logic [9:0] y,
                             input logic [15:0] colour);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_x  <= x;
      req_pixel_y  <= y;
      req_pixel_in <= colour;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_pixels.push_back(overlay_pixel(x, y, colour));
   endtask

   // registers change only with the pipeline empty
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_pixel(10'd0, 10'd0, 16'h1234);
      settle_pipeline();
      write_reg(CSR_ENABLE, 16'h0001);
      send_pixel(10'd0, 10'd0, 16'hAAAA);
      send_pixel(10'd1, 10'd2, 16'h5555);
      send_pixel(10'd1, 10'd0, 16'h0F0F);
      send_pixel(10'd12, 10'd0, 16'hFFFF);
      settle_pipeline();
   endtask

   task automatic test_every_shape();
      write_reg(CSR_POINTER_X, 16'd100);
      write_reg(CSR_POINTER_Y, 16'd100);
      write_reg(CSR_DARK, 16'hFFFF);
      write_reg(CSR_LIGHT, 16'h0000);
      for (int s = 0; s < 8; s++) begin
         write_reg(CSR_SHAPE, 16'(s));
         send_pixel(10'd100, 10'd100, 16'h0000);
         send_pixel(10'd101, 10'd102, 16'hFFFF);
         settle_pipeline();
      end
   endtask

   task automatic test_frame_edges();
      write_reg(CSR_DARK, 16'h1357);
      write_reg(CSR_LIGHT, 16'hECA8);
      // crosshair hotspot puts the icon origin above and left of the frame
      write_reg(CSR_SHAPE, 16'd2);
      write_reg(CSR_POINTER_X, 16'd0);
      write_reg(CSR_POINTER_Y, 16'd0);
      send_pixel(10'd0, 10'd0, 16'h0001);
      send_pixel(10'd1023, 10'd767, 16'h8000);
      settle_pipeline();
      write_reg(CSR_SHAPE, 16'd4);
      write_reg(CSR_POINTER_X, 16'd1023);
      write_reg(CSR_POINTER_Y, 16'd767);
      send_pixel(10'd1023, 10'd767, 16'h2222);
      send_pixel(10'd1016, 10'd765, 16'h3333);
      send_pixel(10'd1016, 10'd760, 16'h4444);
      settle_pipeline();
      // pixel rows below the frame pass through even under the icon
      write_reg(CSR_SHAPE, 16'd0);
      write_reg(CSR_POINTER_Y, 16'd1023);
      send_pixel(10'd1023, 10'd1023, 16'h6666);
      settle_pipeline();
      write_reg(CSR_POINTER_Y, 16'd768);
      send_pixel(10'd1023, 10'd768, 16'h7777);
      settle_pipeline();
   endtask

   task automatic randomize_cursor();
      logic [15:0] x_word;
      logic [15:0] y_word;
      case ($urandom_range(3))
         0:       x_word = 16'($urandom_range(15));
         1:       x_word = 16'($urandom_range(1023, 1008));
         default: x_word = 16'($urandom_range(1023));
      endcase
      case ($urandom_range(3))
         0:       y_word = 16'($urandom_range(15));
         1:       y_word = 16'($urandom_range(783, 752));
         2:       y_word = 16'($urandom_range(1023));
         default: y_word = 16'($urandom_range(767));
      endcase
      x_word[15:10] = 6'($urandom);
      y_word[15:10] = 6'($urandom);
      write_reg(CSR_ENABLE, {15'($urandom), 1'($urandom_range(99) < 88)});
      write_reg(CSR_SHAPE, {13'($urandom), 3'($urandom_range(7))});
      write_reg(CSR_POINTER_X, x_word);
      write_reg(CSR_POINTER_Y, y_word);
      write_reg(CSR_DARK, ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom));
      write_reg(CSR_LIGHT, ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom));
   endtask

   task automatic test_random_overlay(input int idle_pct, input int stall_pct,
                                      input int segments, input int beats);
      int icon;
      int px;
      int py;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int seg = 0; seg < segments; seg++) begin
         randomize_cursor();
         icon = selected_icon();
         for (int n = 0; n < beats; n++) begin
            if ($urandom_range(99) < 70) begin
               px = int'(cursor_cfg.pointer_x) - ICON_HOT_X[icon] + $urandom_range(19) - 2;
               py = int'(cursor_cfg.pointer_y) - ICON_HOT_Y[icon] + $urandom_range(19) - 2;
               if (px < 0 || px > 1023) px = $urandom_range(1023);
               if (py < 0 || py > 1023) py = $urandom_range(1023);
            end else begin
               px = $urandom_range(1023);
               py = $urandom_range(1023);
            end
            send_pixel(10'(px), 10'(py), 16'($urandom));
         end
         settle_pipeline();
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      overlay_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result beat pixel_out %h on_cursor %b",
                   rsp_pixel_out, rsp_on_cursor);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               $error("pixel_out expected %h actual %h", want.pixel, rsp_pixel_out);
               error_count++;
            end
            if (rsp_on_cursor !== want.hit) begin
               $error("on_cursor expected %b actual %b", want.hit, rsp_on_cursor);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_every_shape();
      test_frame_edges();
      test_random_overlay(0, 0, 9, 47);
      test_random_overlay(77, 0, 9, 47);
      test_random_overlay(0, 77, 9, 47);
      test_random_overlay(27, 27, 9, 47);
      settle_pipeline();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
